@@ hdl/pic_pkg.sv @@
`default_nettype none

package pic_pkg;

    // pipeline register stages from input to result
    localparam int STAGES = 9;

    // operand slice width inside the split multipliers
    localparam int CHUNK_BITS = 16;

    localparam int CFG_IDX_BITS = 3;

    localparam logic [CFG_IDX_BITS-1:0] REG_SHAPE_KIND = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_CENTER_X   = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_CENTER_Y   = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_CENTER_Z   = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_APEX_X     = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] REG_APEX_Y     = 3'd5;
    localparam logic [CFG_IDX_BITS-1:0] REG_APEX_Z     = 3'd6;
    localparam logic [CFG_IDX_BITS-1:0] REG_RADIUS     = 3'd7;

    localparam logic SHAPE_SPHERE = 1'b0;

    typedef struct packed {
        logic [STAGES-1:0] en;
        logic              in_ready;
        logic              out_valid;
    } pipe_ctl_t;

    // result already settled before the wide compare
    typedef struct packed {
        logic known;
        logic value;
    } decide_t;

endpackage

`default_nettype wire

@@ hdl/pic_pipe_ctl.sv @@
`default_nettype none

module pic_pipe_ctl
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    input  wire logic               out_ready,
    output pic_pkg::pipe_ctl_t      ctl
);

    logic [pic_pkg::STAGES-1:0] vld_reg;
    logic [pic_pkg::STAGES-1:0] vld_next;
    logic [pic_pkg::STAGES-1:0] en;

    // a stage loads when empty or when its content moves on
    always_comb
    begin
        logic nxt;
        nxt = out_ready;
        for (int k = pic_pkg::STAGES - 1; k >= 0; k--)
        begin
            en[k] = !vld_reg[k] || nxt;
            nxt   = en[k];
        end
    end

    always_comb
    begin
        vld_next[0] = en[0] ? in_valid : vld_reg[0];
        for (int k = 1; k < pic_pkg::STAGES; k++)
        begin
            vld_next[k] = en[k] ? vld_reg[k-1] : vld_reg[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    assign ctl.en        = en;
    assign ctl.in_ready  = en[0];
    assign ctl.out_valid = vld_reg[pic_pkg::STAGES-1];

endmodule

`default_nettype wire

@@ hdl/pic_front.sv @@
`default_nettype none

module pic_front
#(
    parameter int N = 16
)
(
    input  wire logic                  clk,
    input  wire logic [2:0]            en,
    input  wire logic signed [N-1:0]   point_x,
    input  wire logic signed [N-1:0]   point_y,
    input  wire logic signed [N-1:0]   point_z,
    input  wire logic signed [N-1:0]   center_x,
    input  wire logic signed [N-1:0]   center_y,
    input  wire logic signed [N-1:0]   center_z,
    input  wire logic signed [N-1:0]   apex_x,
    input  wire logic signed [N-1:0]   apex_y,
    input  wire logic signed [N-1:0]   apex_z,
    input  wire logic [N-2:0]          radius,
    output logic [2*N+1:0]             dist2,
    output logic [2*N+1:0]             vv,
    output logic [2*N+1:0]             len2,
    output logic signed [2*N+2:0]      dot,
    output logic [2*N-3:0]             r2
);

    localparam int DW  = N + 1;
    localparam int PW  = 2 * N + 2;
    localparam int SQW = 2 * N + 1;
    localparam int SW  = 2 * N + 2;
    localparam int DTW = 2 * N + 3;
    localparam int R2W = 2 * N - 2;

    // stage 1: differences
    logic signed [DW-1:0] w_reg [3];
    logic signed [DW-1:0] v_reg [3];
    logic signed [DW-1:0] a_reg [3];

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            w_reg[0] <= DW'(point_x) - DW'(center_x);
            w_reg[1] <= DW'(point_y) - DW'(center_y);
            w_reg[2] <= DW'(point_z) - DW'(center_z);
            v_reg[0] <= DW'(point_x) - DW'(apex_x);
            v_reg[1] <= DW'(point_y) - DW'(apex_y);
            v_reg[2] <= DW'(point_z) - DW'(apex_z);
            a_reg[0] <= DW'(center_x) - DW'(apex_x);
            a_reg[1] <= DW'(center_y) - DW'(apex_y);
            a_reg[2] <= DW'(center_z) - DW'(apex_z);
        end
    end

    // stage 2: products
    logic signed [PW-1:0] ww_c [3];
    logic signed [PW-1:0] vsq_c [3];
    logic signed [PW-1:0] asq_c [3];
    logic signed [PW-1:0] va_c [3];
    logic [SQW-1:0]       ww_reg [3];
    logic [SQW-1:0]       vsq_reg [3];
    logic [SQW-1:0]       asq_reg [3];
    logic signed [PW-1:0] va_reg [3];
    logic [2*N-3:0]       r2_c;
    logic [2*N-3:0]       r2_2_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            ww_c[i]  = PW'(w_reg[i]) * PW'(w_reg[i]);
            vsq_c[i] = PW'(v_reg[i]) * PW'(v_reg[i]);
            asq_c[i] = PW'(a_reg[i]) * PW'(a_reg[i]);
            va_c[i]  = PW'(v_reg[i]) * PW'(a_reg[i]);
        end
        r2_c = R2W'(radius) * R2W'(radius);
    end

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            for (int i = 0; i < 3; i++)
            begin
                ww_reg[i]  <= ww_c[i][SQW-1:0];
                vsq_reg[i] <= vsq_c[i][SQW-1:0];
                asq_reg[i] <= asq_c[i][SQW-1:0];
                va_reg[i]  <= va_c[i];
            end
            r2_2_reg <= r2_c;
        end
    end

    // stage 3: sums
    logic [SW-1:0]         dist2_reg;
    logic [SW-1:0]         vv_reg;
    logic [SW-1:0]         len2_reg;
    logic signed [DTW-1:0] dot_reg;
    logic [2*N-3:0]        r2_3_reg;

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            dist2_reg <= SW'(ww_reg[0]) + SW'(ww_reg[1]) + SW'(ww_reg[2]);
            vv_reg    <= SW'(vsq_reg[0]) + SW'(vsq_reg[1]) + SW'(vsq_reg[2]);
            len2_reg  <= SW'(asq_reg[0]) + SW'(asq_reg[1]) + SW'(asq_reg[2]);
            dot_reg   <= DTW'(va_reg[0]) + DTW'(va_reg[1]) + DTW'(va_reg[2]);
            r2_3_reg  <= r2_2_reg;
        end
    end

    assign dist2 = dist2_reg;
    assign vv    = vv_reg;
    assign len2  = len2_reg;
    assign dot   = dot_reg;
    assign r2    = r2_3_reg;

endmodule

`default_nettype wire

@@ hdl/pic_mul.sv @@
`default_nettype none

module pic_mul
#(
    parameter int WA = 34,
    parameter int WB = 34
)
(
    input  wire logic             clk,
    input  wire logic             en_a,
    input  wire logic             en_b,
    input  wire logic [WA-1:0]    a,
    input  wire logic [WB-1:0]    b,
    output logic [WA+WB-1:0]      p
);

    localparam int CW = pic_pkg::CHUNK_BITS;
    localparam int NC = (WB + CW - 1) / CW;
    localparam int SW = WA + NC * CW;
    localparam int PPW = WA + CW;

    logic [NC*CW-1:0] b_pad;
    logic [PPW-1:0]   pp_reg [NC];
    logic [SW-1:0]    sum_c;
    logic [SW-1:0]    sum_reg;

    assign b_pad = (NC*CW)'(b);

    // first register: one partial product per slice of b
    always_ff @(posedge clk)
    begin
        if (en_a)
        begin
            for (int k = 0; k < NC; k++)
            begin
                pp_reg[k] <= PPW'(a) * PPW'(b_pad[k*CW +: CW]);
            end
        end
    end

    // second register: aligned sum of the partials
    always_comb
    begin
        sum_c = '0;
        for (int k = 0; k < NC; k++)
        begin
            sum_c = sum_c + (SW'(pp_reg[k]) << (k * CW));
        end
    end

    always_ff @(posedge clk)
    begin
        if (en_b)
        begin
            sum_reg <= sum_c;
        end
    end

    assign p = sum_reg[WA+WB-1:0];

endmodule

`default_nettype wire

@@ hdl/point_in_cone_or_sphere_top.sv @@
// Pipeline: 9 register stages from the accepted request to the result.
// Throughput: one request per cycle unless back-pressure stalls it; every stage holds on its own under
// back-pressure, so empty stages keep filling while the result waits.
// The cone test's wide products run as split multipliers: a partial-product register, then a sum register.
// Reset: asynchronous, active low; clears the stage valid bits and the
// configuration registers to 0; datapath registers are not reset.
`default_nettype none

module point_in_cone_or_sphere_top
#(
    parameter int COORD_BITS = 16
)
(
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_we,
    input  wire logic [pic_pkg::CFG_IDX_BITS-1:0] cfg_idx,
    input  wire logic [COORD_BITS-1:0]            cfg_wdata,
    input  wire logic                             in_valid,
    output logic                                  in_ready,
    input  wire logic signed [COORD_BITS-1:0]     point_x,
    input  wire logic signed [COORD_BITS-1:0]     point_y,
    input  wire logic signed [COORD_BITS-1:0]     point_z,
    output logic                                  out_valid,
    input  wire logic                             out_ready,
    output logic                                  inside_res
);

    localparam int N   = COORD_BITS;
    localparam int SW  = 2 * N + 2;
    localparam int DTW = 2 * N + 3;
    localparam int R2W = 2 * N - 2;
    localparam int QW  = 4 * N + 4;
    localparam int LW  = 6 * N + 6;
    localparam int RW  = 6 * N + 2;

    // configuration
    logic                  shape_kind_reg;
    logic signed [N-1:0]   center_x_reg;
    logic signed [N-1:0]   center_y_reg;
    logic signed [N-1:0]   center_z_reg;
    logic signed [N-1:0]   apex_x_reg;
    logic signed [N-1:0]   apex_y_reg;
    logic signed [N-1:0]   apex_z_reg;
    logic [N-2:0]          radius_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shape_kind_reg <= 1'b0;
            center_x_reg   <= '0;
            center_y_reg   <= '0;
            center_z_reg   <= '0;
            apex_x_reg     <= '0;
            apex_y_reg     <= '0;
            apex_z_reg     <= '0;
            radius_reg     <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_idx)
                pic_pkg::REG_SHAPE_KIND: shape_kind_reg <= cfg_wdata[0];
                pic_pkg::REG_CENTER_X:   center_x_reg   <= $signed(cfg_wdata);
                pic_pkg::REG_CENTER_Y:   center_y_reg   <= $signed(cfg_wdata);
                pic_pkg::REG_CENTER_Z:   center_z_reg   <= $signed(cfg_wdata);
                pic_pkg::REG_APEX_X:     apex_x_reg     <= $signed(cfg_wdata);
                pic_pkg::REG_APEX_Y:     apex_y_reg     <= $signed(cfg_wdata);
                pic_pkg::REG_APEX_Z:     apex_z_reg     <= $signed(cfg_wdata);
                pic_pkg::REG_RADIUS:     radius_reg     <= cfg_wdata[N-2:0];
                default:
                begin
                end
            endcase
        end
    end

    // stage control
    pic_pkg::pipe_ctl_t ctl;

    pic_pipe_ctl u_ctl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .out_ready (out_ready),
        .ctl       (ctl)
    );

    assign in_ready  = ctl.in_ready;
    assign out_valid = ctl.out_valid;

    // stages 1..3
    logic [SW-1:0]         dist2_3;
    logic [SW-1:0]         vv_3;
    logic [SW-1:0]         len2_3;
    logic signed [DTW-1:0] dot_3;
    logic [R2W-1:0]        r2_3;

    pic_front #(.N(N)) u_front
    (
        .clk      (clk),
        .en       (ctl.en[2:0]),
        .point_x  (point_x),
        .point_y  (point_y),
        .point_z  (point_z),
        .center_x (center_x_reg),
        .center_y (center_y_reg),
        .center_z (center_z_reg),
        .apex_x   (apex_x_reg),
        .apex_y   (apex_y_reg),
        .apex_z   (apex_z_reg),
        .radius   (radius_reg),
        .dist2    (dist2_3),
        .vv       (vv_3),
        .len2     (len2_3),
        .dot      (dot_3),
        .r2       (r2_3)
    );

    // stage 4: range checks, sphere result
    logic [SW-1:0]     dot_mag;
    logic              cone_ok;
    pic_pkg::decide_t  dec_c;
    pic_pkg::decide_t  dec4_reg;
    pic_pkg::decide_t  dec5_reg;
    pic_pkg::decide_t  dec6_reg;
    pic_pkg::decide_t  dec7_reg;
    pic_pkg::decide_t  dec8_reg;
    logic [SW-1:0]     len4_reg;
    logic [SW-1:0]     len5_reg;
    logic [SW-1:0]     len6_reg;
    logic [R2W-1:0]    r2_4_reg;
    logic [R2W-1:0]    r2_5_reg;
    logic [R2W-1:0]    r2_6_reg;

    assign dot_mag = dot_3[SW-1:0];

    always_comb
    begin
        cone_ok = (len2_3 != '0) && !dot_3[DTW-1] && (dot_mag <= len2_3);
        if (shape_kind_reg == pic_pkg::SHAPE_SPHERE)
        begin
            dec_c.known = 1'b1;
            dec_c.value = dist2_3 <= SW'(r2_3);
        end
        else
        begin
            dec_c.known = !cone_ok;
            dec_c.value = 1'b0;
        end
    end

    // stages 4..5: L*|v|^2 and d^2
    logic [QW-1:0] lvv_5;
    logic [QW-1:0] dd_5;

    pic_mul #(.WA(SW), .WB(SW)) u_mul_lvv
    (
        .clk  (clk),
        .en_a (ctl.en[3]),
        .en_b (ctl.en[4]),
        .a    (len2_3),
        .b    (vv_3),
        .p    (lvv_5)
    );

    pic_mul #(.WA(SW), .WB(SW)) u_mul_dd
    (
        .clk  (clk),
        .en_a (ctl.en[3]),
        .en_b (ctl.en[4]),
        .a    (dot_mag),
        .b    (dot_mag),
        .p    (dd_5)
    );

    // stage 6: off-axis term
    logic [QW-1:0] e6_reg;
    logic [QW-1:0] dd6_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.en[3])
        begin
            dec4_reg <= dec_c;
            len4_reg <= len2_3;
            r2_4_reg <= r2_3;
        end
        if (ctl.en[4])
        begin
            dec5_reg <= dec4_reg;
            len5_reg <= len4_reg;
            r2_5_reg <= r2_4_reg;
        end
        if (ctl.en[5])
        begin
            dec6_reg <= dec5_reg;
            len6_reg <= len5_reg;
            r2_6_reg <= r2_5_reg;
            e6_reg   <= lvv_5 - dd_5;
            dd6_reg  <= dd_5;
        end
        if (ctl.en[6])
        begin
            dec7_reg <= dec6_reg;
        end
        if (ctl.en[7])
        begin
            dec8_reg <= dec7_reg;
        end
    end

    // stages 7..8: both sides of the cone compare
    logic [LW-1:0] lhs_8;
    logic [RW-1:0] rhs_8;

    pic_mul #(.WA(SW), .WB(QW)) u_mul_lhs
    (
        .clk  (clk),
        .en_a (ctl.en[6]),
        .en_b (ctl.en[7]),
        .a    (len6_reg),
        .b    (e6_reg),
        .p    (lhs_8)
    );

    pic_mul #(.WA(R2W), .WB(QW)) u_mul_rhs
    (
        .clk  (clk),
        .en_a (ctl.en[6]),
        .en_b (ctl.en[7]),
        .a    (r2_6_reg),
        .b    (dd6_reg),
        .p    (rhs_8)
    );

    // stage 9: result
    logic res_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.en[8])
        begin
            res_reg <= dec8_reg.known ? dec8_reg.value : (lhs_8 <= LW'(rhs_8));
        end
    end

    assign inside_res = res_reg;

endmodule

`default_nettype wire
